/* rtl/core/acs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// acs_pkg
// Shared types and constants of the 4-bit accumulator machine step.
// ----------------------------------------------------------------------------
package acs_pkg;

  // Register file geometry
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = 3;
  localparam int DATA_W    = 4;
  localparam int PC_W      = 8;
  localparam int INSTR_W   = 8;

  // Upper-nibble opcodes (bit 7 clear)
  localparam logic [3:0] OP_ILLEGAL = 4'h3;
  localparam logic [3:0] OP_MOVE    = 4'h7;

  // ALU select, taken from instruction bits 5..4
  localparam logic [1:0] ALU_ADD  = 2'd0;
  localparam logic [1:0] ALU_NAND = 2'd1;

  // Register file write request
  typedef struct packed {
    logic                 en;
    logic [REG_IDX_W-1:0] idx;
    logic [DATA_W-1:0]    data;
  } rf_wr_t;

  // Outcome of executing one instruction word
  typedef struct packed {
    logic [PC_W-1:0]   pc;
    logic [DATA_W-1:0] acc;
    logic [DATA_W-1:0] port;
    logic              taken;
    logic              illegal;
  } exec_res_t;

endpackage : acs_pkg
`default_nettype wire

/* rtl/core/acs_regfile.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// acs_regfile
// Eight 4-bit registers: one read port, one write port, register zero tapped.
// ----------------------------------------------------------------------------
module acs_regfile (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [acs_pkg::REG_IDX_W-1:0] rd_idx,
  output logic [acs_pkg::DATA_W-1:0]         rd_data,
  output logic [acs_pkg::DATA_W-1:0]         r0_data,
  input  wire acs_pkg::rf_wr_t               wr
);

  logic [acs_pkg::DATA_W-1:0] regs_r [acs_pkg::NUM_REGS];

  // Read: indices past the populated registers give zero
  always_comb begin
    if (int'(rd_idx) < acs_pkg::NUM_REGS) begin
      rd_data = regs_r[rd_idx];
    end else begin
      rd_data = '0;
    end
  end

  assign r0_data = regs_r[0];

  // Write: drop writes past the populated registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < acs_pkg::NUM_REGS; i++) begin
        regs_r[i] <= '0;
      end
    end else if (wr.en && (int'(wr.idx) < acs_pkg::NUM_REGS)) begin
      regs_r[wr.idx] <= wr.data;
    end
  end

endmodule : acs_regfile
`default_nettype wire

/* rtl/core/acs_exec.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// acs_exec
// Decode and 4-bit ALU: next PC, accumulator, register write and flags.
// ----------------------------------------------------------------------------
module acs_exec (
  input  wire logic [acs_pkg::INSTR_W-1:0] instr,
  input  wire logic [acs_pkg::PC_W-1:0]    pc,
  input  wire logic [acs_pkg::DATA_W-1:0]  acc,
  input  wire logic [acs_pkg::DATA_W-1:0]  rd_data,
  input  wire logic [acs_pkg::DATA_W-1:0]  r0_data,
  output acs_pkg::rf_wr_t                  wr,
  output acs_pkg::exec_res_t               res
);

  logic [3:0]                 nib;
  logic [acs_pkg::DATA_W-1:0] opnd;

  assign nib = instr[7:4];

  always_comb begin
    res         = '0;
    res.pc      = pc + acs_pkg::PC_W'(1);
    res.acc     = acc;
    wr.en       = 1'b0;
    wr.idx      = instr[acs_pkg::REG_IDX_W-1:0];
    wr.data     = acc;
    opnd        = instr[6] ? instr[3:0] : rd_data;

    priority if (instr[7]) begin
      // Branch on accumulator bit 3
      if (acc[3]) begin
        res.pc    = {1'b0, instr[6:0]};
        res.taken = 1'b1;
      end
    end else if (nib == acs_pkg::OP_ILLEGAL) begin
      res.illegal = 1'b1;
    end else if (nib == acs_pkg::OP_MOVE) begin
      // Store when bit 3 set, otherwise load
      if (instr[3]) begin
        wr.en = 1'b1;
      end else begin
        res.acc = rd_data;
      end
    end else begin
      case (instr[5:4])
        acs_pkg::ALU_ADD:  res.acc = acc + opnd;
        acs_pkg::ALU_NAND: res.acc = ~(acc & opnd);
        default:           res.acc = acc ^ opnd;
      endcase
    end

    // Register zero as seen after this instruction
    res.port = (wr.en && (wr.idx == '0)) ? acc : r0_data;
  end

endmodule : acs_exec
`default_nettype wire

/* rtl/core/accumulator_cpu_step.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// accumulator_cpu_step
// One-instruction-per-word step of a 4-bit accumulator machine.
// ----------------------------------------------------------------------------
// Each input word is one instruction byte. It is captured in an input
// register, executed in a single pass of decode and 4-bit ALU against the
// program counter, accumulator and eight registers, and the outcome lands in
// a result register. A new word is taken every clock cycle unless the result
// register is stalled. The machine state is updated as a word leaves the
// input register, so the following word always sees the effect of the one
// before it. in_ready stays high while the input register is empty or
// moving on; a stalled result holds both stages.
// ----------------------------------------------------------------------------
module accumulator_cpu_step (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [acs_pkg::INSTR_W-1:0]  in_instruction,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [acs_pkg::PC_W-1:0]          out_next_pc,
  output logic [acs_pkg::DATA_W-1:0]        out_accumulator_value,
  output logic [acs_pkg::DATA_W-1:0]        out_output_port,
  output logic                              out_branch_taken,
  output logic                              out_illegal_opcode
);

  logic                         s1_valid_r;
  logic [acs_pkg::INSTR_W-1:0]  s1_instr_r;
  logic                         out_valid_r;
  acs_pkg::exec_res_t           out_res_r;
  logic [acs_pkg::PC_W-1:0]     pc_r;
  logic [acs_pkg::DATA_W-1:0]   acc_r;

  logic                         advance;
  logic [acs_pkg::DATA_W-1:0]   rd_data;
  logic [acs_pkg::DATA_W-1:0]   r0_data;
  acs_pkg::rf_wr_t              ex_wr;
  acs_pkg::rf_wr_t              rf_wr;
  acs_pkg::exec_res_t           ex_res;

  // Handshake: advance when the result slot is free or being emptied
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  acs_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_idx  (s1_instr_r[acs_pkg::REG_IDX_W-1:0]),
    .rd_data (rd_data),
    .r0_data (r0_data),
    .wr      (rf_wr)
  );

  acs_exec u_exec (
    .instr   (s1_instr_r),
    .pc      (pc_r),
    .acc     (acc_r),
    .rd_data (rd_data),
    .r0_data (r0_data),
    .wr      (ex_wr),
    .res     (ex_res)
  );

  // Only commit the register write when the word moves on
  always_comb begin
    rf_wr    = ex_wr;
    rf_wr.en = ex_wr.en && advance;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_instr_r <= in_instruction;
    end
  end

  // Machine state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= '0;
      acc_r <= '0;
    end else if (advance) begin
      pc_r  <= ex_res.pc;
      acc_r <= ex_res.acc;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= ex_res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_next_pc           = out_res_r.pc;
  assign out_accumulator_value = out_res_r.acc;
  assign out_output_port       = out_res_r.port;
  assign out_branch_taken      = out_res_r.taken;
  assign out_illegal_opcode    = out_res_r.illegal;

endmodule : accumulator_cpu_step
`default_nettype wire

/* rtl/core/acs_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// acs_checker
// Port-level checks of the accumulator machine step, bound to the top level.
// ----------------------------------------------------------------------------
module acs_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [acs_pkg::PC_W-1:0]    out_next_pc,
  input wire logic [acs_pkg::DATA_W-1:0]  out_accumulator_value,
  input wire logic [acs_pkg::DATA_W-1:0]  out_output_port,
  input wire logic                        out_branch_taken,
  input wire logic                        out_illegal_opcode
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_next_pc)
      && $stable(out_accumulator_value) && $stable(out_output_port)
      && $stable(out_branch_taken) && $stable(out_illegal_opcode))
    else $error("stalled result word changed");

  // A branch and an illegal opcode exclude each other
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_branch_taken && out_illegal_opcode))
    else $error("branch and illegal flags both set");

  // A taken branch lands in the lower half of the address space
  a_branch_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_branch_taken |-> !out_next_pc[acs_pkg::PC_W-1])
    else $error("branch target outside low 7-bit range");

  // No result is shown in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

endmodule : acs_checker

bind accumulator_cpu_step acs_checker u_acs_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_valid),
  .out_ready             (out_ready),
  .out_next_pc           (out_next_pc),
  .out_accumulator_value (out_accumulator_value),
  .out_output_port       (out_output_port),
  .out_branch_taken      (out_branch_taken),
  .out_illegal_opcode    (out_illegal_opcode)
);
`default_nettype wire
